// ===== hw/rtl/ucc_pkg.sv =====
// Shared constants, types and tables for the unix time / calendar converter.
`default_nettype none

package ucc_pkg;

    // Opcodes
    typedef enum logic {
        OP_TO_CAL  = 1'b0,
        OP_TO_UNIX = 1'b1
    } t_op;

    // Pipeline depths
    localparam int S2C_LAT   = 11;                  // seconds -> calendar stages
    localparam int C2S_LAT   = 4;                   // calendar -> seconds stages
    localparam int ALIGN_LAT = S2C_LAT - C2S_LAT;   // pad to equal the longer path
    localparam int TOTAL_LAT = S2C_LAT + 1;         // plus the output register

    // Reciprocal divide constants: q_est = (x * RECIP) >> SHIFT, then one correction
    localparam logic [9:0]  DAY_HI_DIV   = 10'd675;          // 86400 >> 7
    localparam logic [25:0] RECIP_675    = 26'd50903316;     // floor(2^35 / 675)
    localparam logic [17:0] RECIP_1460   = 18'd183859;       // floor(2^28 / 1460)
    localparam logic [18:0] RECIP_365    = 19'd367719;       // floor(2^27 / 365)
    localparam logic [16:0] RECIP_15_HI  = 17'd69905;        // floor(2^20 / 15)
    localparam logic [8:0]  RECIP_15_LO  = 9'd273;           // floor(2^12 / 15)

    // Era handling
    localparam logic [17:0] DOE_OFFSET   = 18'd135080;       // 719468 - 4 * 146097
    localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
    localparam logic [17:0] DOE_LAST     = 18'd146096;
    localparam logic [17:0] CENT_DAYS    = 18'd36524;
    localparam logic [10:0] DAYS_4Y      = 11'd1460;
    localparam logic [8:0]  DAYS_PER_YR  = 9'd365;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [11:0] YEAR_CLAMP   = 12'd2099;
    localparam logic [11:0] ERA_BASE_NEW = 12'd2000;
    localparam logic [11:0] ERA_BASE_OLD = 12'd1600;

    // Calendar -> days: era base minus epoch shift minus one, mod 2^20
    localparam logic [19:0] C2S_BASE_NEW = 20'd11016;        // 730485 - 719468 - 1
    localparam logic [19:0] C2S_BASE_OLD = 20'd913495;       // -135081 mod 2^20
    localparam logic [8:0]  YOE_LAST     = 9'd399;

    // Converted calendar word
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } t_cal_res;

    // First day of year (March based) of month index mi
    function automatic logic [8:0] cal_month_start(input logic [3:0] mi);
        logic [8:0] v;
        case (mi)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            4'd12:   v = 9'd367;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // Weekday offset per month (Jan..Dec)
    function automatic logic [2:0] wd_month_off(input logic [3:0] mon);
        logic [2:0] v;
        case (mon)
            4'd1:    v = 3'd0;
            4'd2:    v = 3'd3;
            4'd3:    v = 3'd2;
            4'd4:    v = 3'd5;
            4'd5:    v = 3'd0;
            4'd6:    v = 3'd3;
            4'd7:    v = 3'd5;
            4'd8:    v = 3'd1;
            4'd9:    v = 3'd4;
            4'd10:   v = 3'd6;
            4'd11:   v = 3'd2;
            4'd12:   v = 3'd4;
            default: v = 3'd4;
        endcase
        return v;
    endfunction

    // x mod 7 for a 6-bit value (8 == 1 mod 7)
    function automatic logic [2:0] mod7_6b(input logic [5:0] x);
        logic [3:0] s;
        s = 4'(x[5:3]) + 4'(x[2:0]);
        if (s >= 4'd14) begin
            s = s - 4'd14;
        end else if (s >= 4'd7) begin
            s = s - 4'd7;
        end
        return s[2:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ucc_s2c.sv =====
// Seconds-to-calendar pipeline: 32-bit unix seconds to date, time and weekday.
`default_nettype none

module ucc_s2c import ucc_pkg::*; (
    input  logic        i_clk,
    input  logic [31:0] i_unix,
    output t_cal_res    o_res
);

    // ---- stage 1: days estimate via reciprocal of 675 on seconds >> 7
    logic [50:0] prod1;
    logic [24:0] r1_x;
    logic [6:0]  r1_lo;
    logic [15:0] r1_qe;

    assign prod1 = 51'(i_unix[31:7]) * 51'(RECIP_675);

    // ---- stage 2: correct days, rebuild second of day
    logic [25:0] prd2, rem2;
    logic        fix2;
    logic [15:0] n2_days;
    logic [9:0]  n2_rem;
    logic [15:0] r2_days;
    logic [16:0] r2_sod;

    assign prd2    = 26'(r1_qe) * 26'(DAY_HI_DIV);
    assign rem2    = 26'(r1_x) - prd2;
    assign fix2    = rem2 >= 26'(DAY_HI_DIV);
    assign n2_days = fix2 ? r1_qe + 16'd1 : r1_qe;
    assign n2_rem  = fix2 ? 10'(rem2 - 26'(DAY_HI_DIV)) : 10'(rem2);

    // ---- stage 3: day of era, quick weekday, minutes estimate
    logic [17:0] sum3;
    logic        n3_era5;
    logic [17:0] n3_doe;
    logic [5:0]  fold3;
    logic [31:0] prod3;
    logic [17:0] r3_doe;
    logic        r3_era5;
    logic [2:0]  r3_wdf;
    logic [16:0] r3_sod;
    logic [10:0] r3_me;

    assign sum3    = 18'(r2_days) + DOE_OFFSET;
    assign n3_era5 = sum3 >= DAYS_PER_ERA;
    assign n3_doe  = n3_era5 ? sum3 - DAYS_PER_ERA : sum3;
    // days mod 7 by octal digit folding, shifted so day 0 maps to Thursday
    assign fold3   = 6'(r2_days[2:0]) + 6'(r2_days[5:3]) + 6'(r2_days[8:6])
                   + 6'(r2_days[11:9]) + 6'(r2_days[14:12]) + 6'(r2_days[15])
                   + 6'd3;
    assign prod3   = 32'(r2_sod[16:2]) * 32'(RECIP_15_HI);

    // ---- stage 4: 4-year estimate, century count, minutes/seconds correction
    logic [35:0] prod4;
    logic [2:0]  cnt4;
    logic [1:0]  n4_bc;
    logic [16:0] rem4;
    logic        fix4;
    logic [17:0] r4_doe;
    logic        r4_era5;
    logic [2:0]  r4_wdf;
    logic [7:0]  r4_ae;
    logic [1:0]  r4_bc;
    logic [10:0] r4_mt;
    logic [5:0]  r4_sec;

    assign prod4 = 36'(r3_doe) * 36'(RECIP_1460);
    assign cnt4  = 3'(r3_doe >= CENT_DAYS) + 3'(r3_doe >= 18'(2 * 36524))
                 + 3'(r3_doe >= 18'(3 * 36524)) + 3'(r3_doe >= DOE_LAST);
    assign n4_bc = 2'(cnt4 - 3'(r3_doe == DOE_LAST));
    assign rem4  = r3_sod - 17'(r3_me) * 17'd60;
    assign fix4  = rem4 >= 17'd60;

    // ---- stage 5: 4-year correction, hours estimate
    logic [17:0] rem5;
    logic        fix5;
    logic [17:0] prod5;
    logic [17:0] r5_doe;
    logic        r5_era5;
    logic [2:0]  r5_wdf;
    logic [6:0]  r5_a;
    logic [1:0]  r5_bc;
    logic [10:0] r5_mt;
    logic [5:0]  r5_sec;
    logic [4:0]  r5_he;

    assign rem5  = r4_doe - 18'(r4_ae) * 18'(DAYS_4Y);
    assign fix5  = rem5 >= 18'(DAYS_4Y);
    assign prod5 = 18'(r4_mt[10:2]) * 18'(RECIP_15_LO);

    // ---- stage 6: leap-adjusted day count, hours/minutes correction
    logic [10:0] rem6;
    logic        fix6;
    logic [17:0] r6_doe;
    logic        r6_era5;
    logic [2:0]  r6_wdf;
    logic [17:0] r6_t;
    logic [4:0]  r6_hour;
    logic [5:0]  r6_min;
    logic [5:0]  r6_sec;

    assign rem6 = r5_mt - 11'(r5_he) * 11'd60;
    assign fix6 = rem6 >= 11'd60;

    // ---- stage 7: year of era estimate
    logic [36:0] prod7;
    logic [17:0] r7_doe;
    logic        r7_era5;
    logic [2:0]  r7_wdf;
    logic [17:0] r7_t;
    logic [9:0]  r7_ye;
    logic [4:0]  r7_hour;
    logic [5:0]  r7_min;
    logic [5:0]  r7_sec;

    assign prod7 = 37'(r6_t) * 37'(RECIP_365);

    // ---- stage 8: year of era correction
    logic [17:0] rem8;
    logic        fix8;
    logic [17:0] r8_doe;
    logic        r8_era5;
    logic [2:0]  r8_wdf;
    logic [8:0]  r8_yoe;
    logic [4:0]  r8_hour;
    logic [5:0]  r8_min;
    logic [5:0]  r8_sec;

    assign rem8 = r7_t - 18'(r7_ye) * 18'(DAYS_PER_YR);
    assign fix8 = rem8 >= 18'(DAYS_PER_YR);

    // ---- stage 9: day of year
    logic [1:0]  cent9;
    logic [17:0] ybase9;
    logic [8:0]  r9_doy;
    logic        r9_era5;
    logic [2:0]  r9_wdf;
    logic [8:0]  r9_yoe;
    logic [4:0]  r9_hour;
    logic [5:0]  r9_min;
    logic [5:0]  r9_sec;

    assign cent9  = 2'(r8_yoe >= 9'd100) + 2'(r8_yoe >= 9'd200) + 2'(r8_yoe >= 9'd300);
    assign ybase9 = 18'(r8_yoe) * 18'(DAYS_PER_YR) + 18'(r8_yoe[8:2]) - 18'(cent9);

    // ---- stage 10: month and day
    logic [3:0]  mp10;
    logic [8:0]  dd10;
    logic [3:0]  r10_mon;
    logic [4:0]  r10_day;
    logic        r10_era5;
    logic [2:0]  r10_wdf;
    logic [8:0]  r10_yoe;
    logic [4:0]  r10_hour;
    logic [5:0]  r10_min;
    logic [5:0]  r10_sec;

    always_comb begin
        mp10 = '0;
        for (int k = 1; k < 12; k++) begin
            mp10 = mp10 + 4'(r9_doy >= cal_month_start(4'(k)));
        end
    end

    assign dd10 = r9_doy - cal_month_start(mp10) + 9'd1;

    // ---- stage 11: year, clamp, weekday
    logic [11:0] year11;
    logic        clamp11;
    logic [5:0]  wsum11;
    logic [2:0]  wslow11;
    logic [2:0]  wd11;
    t_cal_res    n11_res;

    assign year11  = 12'(r10_yoe) + (r10_era5 ? ERA_BASE_NEW : ERA_BASE_OLD)
                   + 12'(r10_mon <= 4'd2);
    assign clamp11 = year11 > YEAR_CLAMP;
    // clamped date: year term fixed at 2099 (2098 for Jan/Feb), mod 7 gives 4 / 3
    assign wsum11  = ((r10_mon < 4'd3) ? 6'd3 : 6'd4) + 6'(wd_month_off(r10_mon))
                   + 6'(r10_day);
    assign wslow11 = mod7_6b(wsum11);
    assign wd11    = clamp11 ? ((wslow11 == 3'd0) ? 3'd7 : wslow11) : r10_wdf + 3'd1;

    always_comb begin
        n11_res.year    = clamp11 ? YEAR_CLAMP : year11;
        n11_res.month   = r10_mon;
        n11_res.day     = r10_day;
        n11_res.hour    = r10_hour;
        n11_res.minute  = r10_min;
        n11_res.second  = r10_sec;
        n11_res.weekday = wd11;
    end

    always_ff @(posedge i_clk) begin
        // 1
        r1_x     <= i_unix[31:7];
        r1_lo    <= i_unix[6:0];
        r1_qe    <= prod1[50:35];
        // 2
        r2_days  <= n2_days;
        r2_sod   <= {n2_rem, r1_lo};
        // 3
        r3_doe   <= n3_doe;
        r3_era5  <= n3_era5;
        r3_wdf   <= mod7_6b(fold3);
        r3_sod   <= r2_sod;
        r3_me    <= prod3[30:20];
        // 4
        r4_doe   <= r3_doe;
        r4_era5  <= r3_era5;
        r4_wdf   <= r3_wdf;
        r4_ae    <= prod4[35:28];
        r4_bc    <= n4_bc;
        r4_mt    <= fix4 ? r3_me + 11'd1 : r3_me;
        r4_sec   <= fix4 ? 6'(rem4 - 17'd60) : 6'(rem4);
        // 5
        r5_doe   <= r4_doe;
        r5_era5  <= r4_era5;
        r5_wdf   <= r4_wdf;
        r5_a     <= 7'(r4_ae + 8'(fix5));
        r5_bc    <= r4_bc;
        r5_mt    <= r4_mt;
        r5_sec   <= r4_sec;
        r5_he    <= prod5[16:12];
        // 6
        r6_doe   <= r5_doe;
        r6_era5  <= r5_era5;
        r6_wdf   <= r5_wdf;
        r6_t     <= r5_doe - 18'(r5_a) + 18'(r5_bc);
        r6_hour  <= fix6 ? r5_he + 5'd1 : r5_he;
        r6_min   <= fix6 ? 6'(rem6 - 11'd60) : 6'(rem6);
        r6_sec   <= r5_sec;
        // 7
        r7_doe   <= r6_doe;
        r7_era5  <= r6_era5;
        r7_wdf   <= r6_wdf;
        r7_t     <= r6_t;
        r7_ye    <= prod7[36:27];
        r7_hour  <= r6_hour;
        r7_min   <= r6_min;
        r7_sec   <= r6_sec;
        // 8
        r8_doe   <= r7_doe;
        r8_era5  <= r7_era5;
        r8_wdf   <= r7_wdf;
        r8_yoe   <= 9'(r7_ye + 10'(fix8));
        r8_hour  <= r7_hour;
        r8_min   <= r7_min;
        r8_sec   <= r7_sec;
        // 9
        r9_doy   <= 9'(r8_doe - ybase9);
        r9_era5  <= r8_era5;
        r9_wdf   <= r8_wdf;
        r9_yoe   <= r8_yoe;
        r9_hour  <= r8_hour;
        r9_min   <= r8_min;
        r9_sec   <= r8_sec;
        // 10
        r10_mon  <= (mp10 < 4'd10) ? mp10 + 4'd3 : mp10 - 4'd9;
        r10_day  <= 5'(dd10);
        r10_era5 <= r9_era5;
        r10_wdf  <= r9_wdf;
        r10_yoe  <= r9_yoe;
        r10_hour <= r9_hour;
        r10_min  <= r9_min;
        r10_sec  <= r9_sec;
        // 11
        o_res    <= n11_res;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ucc_c2s.sv =====
// Calendar-to-seconds pipeline: 2000-based date and time to 32-bit unix seconds.
`default_nettype none

module ucc_c2s import ucc_pkg::*; (
    input  logic        i_clk,
    input  logic [6:0]  i_year_offset,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [5:0]  i_second,
    output logic [31:0] o_unix
);

    // ---- stage 1: March-based year of era, day of year (+1), time of day
    logic        early1;
    logic        n1_era5;
    logic [3:0]  mi1;
    logic [8:0]  r1_yoe;
    logic        r1_era5;
    logic [9:0]  r1_doyd;
    logic [16:0] r1_tod;

    assign early1  = i_month <= 4'd2;
    // year 1999 (offset 0, Jan/Feb) falls in the previous era
    assign n1_era5 = (i_year_offset != 7'd0) || !early1;
    assign mi1     = early1 ? i_month + 4'd9 : i_month - 4'd3;

    // ---- stage 2: days since epoch
    logic [1:0]  cent2;
    logic [19:0] sum2;
    logic [16:0] r2_days;
    logic [16:0] r2_tod;

    assign cent2 = 2'(r1_yoe >= 9'd100) + 2'(r1_yoe >= 9'd200) + 2'(r1_yoe >= 9'd300);
    assign sum2  = 20'(r1_yoe) * 20'(DAYS_PER_YR) + 20'(r1_yoe[8:2]) - 20'(cent2)
                 + 20'(r1_doyd) + (r1_era5 ? C2S_BASE_NEW : C2S_BASE_OLD);

    // ---- stage 3: days to seconds
    logic [33:0] prod3;
    logic [31:0] r3_prod;
    logic [16:0] r3_tod;

    assign prod3 = 34'(r2_days) * 34'(SECS_PER_DAY);

    // ---- stage 4 and alignment line
    logic [31:0] r_dly [ALIGN_LAT+1];

    always_ff @(posedge i_clk) begin
        r1_yoe   <= n1_era5 ? 9'(i_year_offset) - 9'(early1) : YOE_LAST;
        r1_era5  <= n1_era5;
        r1_doyd  <= 10'(cal_month_start(mi1)) + 10'(i_day);
        r1_tod   <= 17'(i_hour) * 17'd3600 + 17'(i_minute) * 17'd60 + 17'(i_second);
        r2_days  <= sum2[16:0];
        r2_tod   <= r1_tod;
        r3_prod  <= prod3[31:0];
        r3_tod   <= r2_tod;
        r_dly[0] <= r3_prod + 32'(r3_tod);
        for (int k = 1; k <= ALIGN_LAT; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    assign o_unix = r_dly[ALIGN_LAT];

endmodule

`default_nettype wire

// ===== hw/rtl/unix_time_calendar_converter_core.sv =====
// Top level: two-way unix seconds / calendar converter, fully pipelined.
//
//  channel   | handshake           | word
//  ----------+---------------------+-----------------------------------------------
//  request   | start / busy        | i_opcode, i_unix_in, i_year_offset_in,
//            |                     | i_month_in, i_day_in, i_hour_in, i_minute_in,
//            |                     | i_second_in
//  result    | o_done (one cycle)  | o_unix_out, o_year_out, o_month_out, o_day_out,
//            |                     | o_hour_out, o_minute_out, o_second_out,
//            |                     | o_weekday_out
//
// One word is taken per clock while busy is low; each result passes the 11 stages
// of the seconds-to-calendar datapath, set by its chain of reciprocal multiplies,
// plus the output register. The calendar-to-seconds path is 4 stages and is
// padded to the same depth, so results keep order.
// busy is high only during reset and for the first edge leaving it.
// Reset (synchronous, active low) clears the valid line; data registers are not reset.
// The result side has no backpressure, so nothing in the pipe ever stalls.
`default_nettype none

module unix_time_calendar_converter_core import ucc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [31:0] i_unix_in,
    input  logic [6:0]  i_year_offset_in,
    input  logic [3:0]  i_month_in,
    input  logic [4:0]  i_day_in,
    input  logic [4:0]  i_hour_in,
    input  logic [5:0]  i_minute_in,
    input  logic [5:0]  i_second_in,
    output logic        o_done,
    output logic [31:0] o_unix_out,
    output logic [11:0] o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out,
    output logic [4:0]  o_hour_out,
    output logic [5:0]  o_minute_out,
    output logic [5:0]  o_second_out,
    output logic [2:0]  o_weekday_out
);

    logic                 accept;
    logic                 r_busy;
    logic [S2C_LAT-1:0]   r_vld;
    t_op                  r_op [S2C_LAT];
    t_cal_res             cal_res;
    logic [31:0]          unix_res;
    logic                 r_done;
    logic [31:0]          r_unix;
    t_cal_res             r_cal;
    logic [31:0]          n_unix;
    t_cal_res             n_cal;

    assign accept = start && !busy;
    assign busy   = r_busy;

    ucc_s2c u_s2c (
        .i_clk  (i_clk),
        .i_unix (i_unix_in),
        .o_res  (cal_res)
    );

    ucc_c2s u_c2s (
        .i_clk         (i_clk),
        .i_year_offset (i_year_offset_in),
        .i_month       (i_month_in),
        .i_day         (i_day_in),
        .i_hour        (i_hour_in),
        .i_minute      (i_minute_in),
        .i_second      (i_second_in),
        .o_unix        (unix_res)
    );

    // valid bits and opcode ride alongside the datapath stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[S2C_LAT-2:0], accept};
            r_done <= r_vld[S2C_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_op[0] <= t_op'(i_opcode);
        for (int k = 1; k < S2C_LAT; k++) begin
            r_op[k] <= r_op[k-1];
        end
        r_unix <= n_unix;
        r_cal  <= n_cal;
    end

    // fields not produced by the selected direction read as zero
    assign n_unix = (r_op[S2C_LAT-1] == OP_TO_UNIX) ? unix_res : '0;
    assign n_cal  = (r_op[S2C_LAT-1] == OP_TO_CAL) ? cal_res : '0;

    assign o_done        = r_done;
    assign o_unix_out    = r_unix;
    assign o_year_out    = r_cal.year;
    assign o_month_out   = r_cal.month;
    assign o_day_out     = r_cal.day;
    assign o_hour_out    = r_cal.hour;
    assign o_minute_out  = r_cal.minute;
    assign o_second_out  = r_cal.second;
    assign o_weekday_out = r_cal.weekday;

    // every accepted word comes out as an o_done result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##TOTAL_LAT o_done)
        else $error("result missing at fixed latency");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> ##TOTAL_LAT !o_done)
        else $error("result without request");

    // a calendar result never carries a seconds value
    a_dir_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_year_out != 12'd0) |-> (o_unix_out == 32'd0))
        else $error("both directions driven");

    a_cal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_year_out != 12'd0) |->
            (o_year_out >= 12'd1970 && o_year_out <= YEAR_CLAMP
             && o_month_out >= 4'd1 && o_month_out <= 4'd12
             && o_day_out >= 5'd1 && o_weekday_out != 3'd0))
        else $error("calendar word out of range");

    a_tod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_hour_out < 5'd24 && o_minute_out < 6'd60 && o_second_out < 6'd60))
        else $error("time of day out of range");

endmodule

`default_nettype wire

// ===== verif/tb_unix_time_calendar_converter_core.sv =====
// Self-checking testbench for the unix seconds / calendar converter core.
`timescale 1ns / 100ps

module tb_unix_time_calendar_converter_core;

    import ucc_pkg::t_op, ucc_pkg::OP_TO_CAL, ucc_pkg::OP_TO_UNIX, ucc_pkg::TOTAL_LAT;

    // Calendar arithmetic constants, all 32-bit so every step wraps like the hardware spec
    localparam bit [31:0] EPOCH_DAYS = 32'd719468;  // days from 0000-03-01 to 1970-01-01
    localparam bit [31:0] ERA_DAYS   = 32'd146097;  // days in 400 years
    localparam bit [31:0] DAY_SECS   = 32'd86400;
    localparam bit [31:0] LAST_YEAR  = 32'd2099;

    // Weekday offset per month, January first
    localparam bit [2:0] WD_OFFSET [12] = '{3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3,
                                            3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4};

    localparam int MAX_GAP       = 40;   // longest sender idle run
    localparam int STALL_LIMIT   = 600;  // cycles without any handshake before giving up
    localparam int PRINT_LIMIT   = 30;   // mismatch lines shown, the rest only counted

    // One request word as driven on the input ports
    typedef struct {
        t_op         op;
        logic [31:0] unix;
        logic [6:0]  yoff;
        logic [3:0]  mon;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } conv_req_t;

    // One result word
    typedef struct {
        logic [31:0] unix;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } conv_word_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_opcode;
    logic [31:0] i_unix_in;
    logic [6:0]  i_year_offset_in;
    logic [3:0]  i_month_in;
    logic [4:0]  i_day_in;
    logic [4:0]  i_hour_in;
    logic [5:0]  i_minute_in;
    logic [5:0]  i_second_in;
    logic        o_done;
    logic [31:0] o_unix_out;
    logic [11:0] o_year_out;
    logic [3:0]  o_month_out;
    logic [4:0]  o_day_out;
    logic [4:0]  o_hour_out;
    logic [5:0]  o_minute_out;
    logic [5:0]  o_second_out;
    logic [2:0]  o_weekday_out;

    conv_word_t  pending_words[$];   // predicted results, oldest first
    int          mismatches  = 0;
    int          results_seen = 0;
    int          stall_cycles = 0;
    int          idle_pct     = 0;   // chance in percent that the sender pauses a cycle

    unix_time_calendar_converter_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_unix_in        (i_unix_in),
        .i_year_offset_in (i_year_offset_in),
        .i_month_in       (i_month_in),
        .i_day_in         (i_day_in),
        .i_hour_in        (i_hour_in),
        .i_minute_in      (i_minute_in),
        .i_second_in      (i_second_in),
        .o_done           (o_done),
        .o_unix_out       (o_unix_out),
        .o_year_out       (o_year_out),
        .o_month_out      (o_month_out),
        .o_day_out        (o_day_out),
        .o_hour_out       (o_hour_out),
        .o_minute_out     (o_minute_out),
        .o_second_out     (o_second_out),
        .o_weekday_out    (o_weekday_out)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Predictor: civil-date conversion in plain 32-bit wrapping arithmetic
    // ------------------------------------------------------------------
    function automatic conv_word_t convert_word(input conv_req_t rq);
        conv_word_t w;
        bit [31:0]  days, sod, z, era, doe, yoe, doy, mp, yr, mon, dd, y, wsum, mi, r;
        w = '{default: '0};
        if (rq.op == OP_TO_CAL) begin
            days = rq.unix / DAY_SECS;
            sod  = rq.unix % DAY_SECS;
            // era-based split, March-based year so leap day is last
            z    = days + EPOCH_DAYS;
            era  = z / ERA_DAYS;
            doe  = z - era * ERA_DAYS;
            yoe  = (doe - doe / 32'd1460 + doe / 32'd36524 - doe / 32'd146096) / 32'd365;
            doy  = doe - (32'd365 * yoe + yoe / 32'd4 - yoe / 32'd100);
            mp   = (32'd5 * doy + 32'd2) / 32'd153;
            dd   = doy - (32'd153 * mp + 32'd2) / 32'd5 + 32'd1;
            mon  = (mp < 32'd10) ? mp + 32'd3 : mp - 32'd9;
            yr   = yoe + era * 32'd400 + ((mon <= 32'd2) ? 32'd1 : 32'd0);
            // clamp only the year; month/day stay from the real date
            if (yr > LAST_YEAR) begin
                yr = LAST_YEAR;
            end
            w.year   = yr[11:0];
            w.month  = mon[3:0];
            w.day    = dd[4:0];
            w.hour   = 5'(sod / 32'd3600);
            w.minute = 6'((sod / 32'd60) % 32'd60);
            w.second = 6'(sod % 32'd60);
            // weekday from the clamped date
            y    = yr - ((mon < 32'd3) ? 32'd1 : 32'd0);
            wsum = (y + y / 32'd4 - y / 32'd100 + y / 32'd400
                    + 32'(WD_OFFSET[4'((mon - 32'd1) % 32'd12)]) + dd) % 32'd7;
            w.weekday = (wsum == 32'd0) ? 3'd7 : wsum[2:0];
        end else begin
            mon = 32'(rq.mon);
            y   = 32'd2000 + 32'(rq.yoff) - ((mon <= 32'd2) ? 32'd1 : 32'd0);
            era = y / 32'd400;
            yoe = y - era * 32'd400;
            // months 0..2 and 13..15 land where the March-based index puts them
            mi  = (mon > 32'd2) ? mon - 32'd3 : mon + 32'd9;
            doy = (32'd153 * mi + 32'd2) / 32'd5 + 32'(rq.day) - 32'd1;
            doe = yoe * 32'd365 + yoe / 32'd4 - yoe / 32'd100 + doy;
            days = era * ERA_DAYS + doe - EPOCH_DAYS;
            r = days * DAY_SECS + 32'(rq.hour) * 32'd3600 + 32'(rq.minute) * 32'd60
                + 32'(rq.second);
            w.unix = r;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_LIMIT) begin
            $display("[%0t] result %0d: %s got %0d expected %0d",
                     $realtime, results_seen, what, got, want);
        end
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: predicts at request acceptance, compares at o_done.
    // Everything here reads pre-edge values, so ordering within the step
    // does not matter. Also runs the no-progress watchdog.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        conv_req_t  rq;
        conv_word_t want;
        bit         moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                rq.op     = t_op'(i_opcode);
                rq.unix   = i_unix_in;
                rq.yoff   = i_year_offset_in;
                rq.mon    = i_month_in;
                rq.day    = i_day_in;
                rq.hour   = i_hour_in;
                rq.minute = i_minute_in;
                rq.second = i_second_in;
                pending_words.push_back(convert_word(rq));
                moved = 1'b1;
            end
            if (o_done) begin
                moved = 1'b1;
                if (pending_words.size() == 0) begin
                    report_mismatch("unexpected result word, unix", o_unix_out, 32'd0);
                end else begin
                    want = pending_words.pop_front();
                    check_field("unix",    o_unix_out,         want.unix);
                    check_field("year",    32'(o_year_out),    32'(want.year));
                    check_field("month",   32'(o_month_out),   32'(want.month));
                    check_field("day",     32'(o_day_out),     32'(want.day));
                    check_field("hour",    32'(o_hour_out),    32'(want.hour));
                    check_field("minute",  32'(o_minute_out),  32'(want.minute));
                    check_field("second",  32'(o_second_out),  32'(want.second));
                    check_field("weekday", 32'(o_weekday_out), 32'(want.weekday));
                end
                results_seen++;
            end
        end
        if (moved) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[%0t] watchdog: no handshake for %0d cycles, %0d words pending",
                         $realtime, stall_cycles, pending_words.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Fully random word; fields the opcode ignores keep random content
    function automatic conv_req_t random_word();
        conv_req_t rq;
        rq.op     = t_op'($urandom_range(1));
        rq.unix   = $urandom;
        rq.yoff   = 7'($urandom);
        rq.mon    = 4'($urandom);
        rq.day    = 5'($urandom);
        rq.hour   = 5'($urandom);
        rq.minute = 6'($urandom);
        rq.second = 6'($urandom);
        return rq;
    endfunction

    // Drive one word, hold until accepted, then maybe pause. start is only
    // lowered when a pause follows, so back-to-back words keep it high.
    task automatic send_word(input conv_req_t rq);
        int gap;
        start            <= 1'b1;
        i_opcode         <= rq.op;
        i_unix_in        <= rq.unix;
        i_year_offset_in <= rq.yoff;
        i_month_in       <= rq.mon;
        i_day_in         <= rq.day;
        i_hour_in        <= rq.hour;
        i_minute_in      <= rq.minute;
        i_second_in      <= rq.second;
        do begin
            @(posedge i_clk);
        end while (busy);
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_to_cal(input logic [31:0] secs);
        conv_req_t rq;
        rq      = random_word();
        rq.op   = OP_TO_CAL;
        rq.unix = secs;
        send_word(rq);
    endtask

    task automatic send_to_unix(input logic [6:0] yoff, input logic [3:0] mon,
                                input logic [4:0] day, input logic [4:0] hour,
                                input logic [5:0] minute, input logic [5:0] second);
        conv_req_t rq;
        rq        = random_word();
        rq.op     = OP_TO_UNIX;
        rq.yoff   = yoff;
        rq.mon    = mon;
        rq.day    = day;
        rq.hour   = hour;
        rq.minute = minute;
        rq.second = second;
        send_word(rq);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Epoch, day edges, century change and leap day
    task automatic test_to_calendar_edges();
        send_to_cal(32'd0);
        send_to_cal(32'd86399);
        send_to_cal(32'd86400);
        send_to_cal(32'd946684799);
        send_to_cal(32'd946684800);
        send_to_cal(32'd951782400);     // 2000-02-29
    endtask

    // Dates past 2099 keep month and day, year pinned
    task automatic test_year_clamp();
        send_to_cal(32'd4102444799);    // last second of 2099
        send_to_cal(32'd4102444800);    // 2100-01-01
        send_to_cal(32'd4233686399);
        send_to_cal(32'd4233686400);    // 2104-02-29 weekday taken against 2099
        send_to_cal(32'hFFFF_FFFF);
    endtask

    // Legal calendar words at both ends of the range
    task automatic test_to_unix_edges();
        send_to_unix(7'd0,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0);
        send_to_unix(7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
        send_to_unix(7'd0,  4'd2,  5'd29, 5'd12, 6'd30, 6'd30);
        send_to_unix(7'd38, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0);
    endtask

    // Unvalidated calendar input: odd months, day 0, overlong time, wrap past 2^32
    task automatic test_unchecked_calendar();
        send_to_unix(7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
        send_to_unix(7'd5,   4'd0,  5'd0,  5'd0,  6'd0,  6'd0);
        send_to_unix(7'd64,  4'd13, 5'd16, 5'd24, 6'd60, 6'd60);
        send_to_unix(7'd100, 4'd14, 5'd0,  5'd17, 6'd42, 6'd9);
    endtask

    // Random mix of both directions, weighted toward interesting dates
    task automatic test_random_traffic(input int count, input int pct);
        conv_req_t rq;
        int        n;
        idle_pct = pct;
        for (n = 0; n < count; n++) begin
            rq = random_word();
            if (rq.op == OP_TO_CAL) begin
                case ($urandom_range(3))
                    0: rq.unix = $urandom;
                    // around the 2100 clamp point
                    1: rq.unix = 32'd4102444800 + $urandom_range(34560000) - 32'd17280000;
                    // just around midnight
                    2: rq.unix = 32'($urandom_range(49710)) * DAY_SECS
                                 + $urandom_range(3) - 32'd2;
                    default: rq.unix = 32'($urandom_range(49709)) * DAY_SECS
                                       + $urandom_range(86399);
                endcase
            end else if ($urandom_range(99) < 80) begin
                rq.yoff   = 7'($urandom_range(99));
                rq.mon    = 4'($urandom_range(12, 1));
                rq.day    = 5'($urandom_range(31, 1));
                rq.hour   = 5'($urandom_range(23));
                rq.minute = 6'($urandom_range(59));
                rq.second = 6'($urandom_range(59));
            end
            send_word(rq);
        end
        idle_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_opcode         <= OP_TO_CAL;
        i_unix_in        <= '0;
        i_year_offset_in <= '0;
        i_month_in       <= '0;
        i_day_in         <= '0;
        i_hour_in        <= '0;
        i_minute_in      <= '0;
        i_second_in      <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_to_calendar_edges();
        test_year_clamp();
        test_to_unix_edges();
        test_unchecked_calendar();
        test_random_traffic(440, 0);
        test_random_traffic(440, 60);
        test_random_traffic(440, 18);
        test_random_traffic(430, 0);
        start <= 1'b0;

        // drain the pipe, then give stray words time to show up
        while (pending_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TOTAL_LAT + 4) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
